@@ rtl/sensor_two_point_calibrator_assert.svh @@
// Assertion macros for the sensor two-point calibrator.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef SENSOR_TWO_POINT_CALIBRATOR_ASSERT_SVH
`define SENSOR_TWO_POINT_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/spc_pkg.sv @@
// Shared types and constants for the sensor two-point calibrator.
// No dependencies.
package spc_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned VALUE_W      = 24;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Datapath widths: |r1 - r0| < 128, |sample - raw0| < 65536
  localparam int unsigned DIFF_W  = 17;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned REFU_W  = 7;
  localparam int unsigned PROD_W  = 23;

  // Serial step counts
  localparam int unsigned MUL_STEPS = REFU_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned CNT_W     = 5;

  // Humidity upper clamp in whole percent
  localparam int HUMID_MAX = 100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF0_X8  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF1_X8  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF0_RAW = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF1_RAW = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF0_X2   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF1_X2   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF0_RAW  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF1_RAW  = 4'd7;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SGN,
    ST_ADJ,
    ST_DONE
  } state_t;

endpackage

@@ rtl/sensor_two_point_calibrator.sv @@
// Two-point linear calibration of temperature and humidity samples.
// Serial shift-add multiplier and restoring divider, one bit per cycle.
// Depends on spc_pkg and sensor_two_point_calibrator_assert.svh.
// A conversion runs from input word through 7 multiply steps, 23 divide steps,
// sign, offset and output load; a held result or a zero-denominator fault goes
// straight to the output load. One word in flight: a new word is taken only
// once the last result is in the output register, which can stall on out_tready.
// Reset (rst_n, synchronous): sequencer, config, output valid and held values
// cleared to zero; datapath registers load on accept and are not reset.
`include "sensor_two_point_calibrator_assert.svh"

module sensor_two_point_calibrator #(
  parameter int unsigned SAMPLE_BITS = spc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [spc_pkg::SAMPLE_W-1:0]   in_tdata,   // [15:0] raw_sample
  input  logic [1:0]                     in_tuser,   // [0] op, [1] sample_ready
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [spc_pkg::VALUE_W-1:0]    out_tdata,  // [23:0] scaled_value
  output logic [1:0]                     out_tuser   // [0] from_hold, [1] divide_fault
);
  import spc_pkg::*;

  // Config registers
  logic [9:0]          t_ref0_x8_r, t_ref1_x8_r;
  logic [SAMPLE_W-1:0] t_raw0_r, t_raw1_r;
  logic [7:0]          h_ref0_x2_r, h_ref1_x2_r;
  logic [SAMPLE_W-1:0] h_raw0_r, h_raw1_r;

  // Control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [VALUE_W-1:0] held_t_r, held_t_nxt;
  logic [VALUE_W-1:0] held_h_r, held_h_nxt;

  // Payload registers
  logic               op_r, op_nxt;
  logic               neg_r, neg_nxt;
  logic               hold_r, hold_nxt;
  logic               fault_r, fault_nxt;
  logic [REFU_W-1:0]  r0_r, r0_nxt;
  logic [REFU_W-1:0]  mplier_r, mplier_nxt;
  logic [MAG_W-1:0]   mcand_r, mcand_nxt;
  logic [MAG_W-1:0]   den_r, den_nxt;
  logic [MAG_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [VALUE_W-1:0] res_r, res_nxt;
  logic [VALUE_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]         out_tuser_r, out_tuser_nxt;

  logic in_fire, cfg_fire, out_free;

  // Front-end operand selection
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [DIFF_W-1:0]      sample_x, raw0_x, raw1_x, ds, den_s;
  logic signed [7:0]             dr;
  logic [REFU_W-1:0]             ref0_u, ref1_u;
  logic [MAG_W-1:0]              ds_mag, den_mag;
  logic [REFU_W-1:0]             dr_mag;
  logic [VALUE_W-1:0]            held_sel;

  // Serial step logic
  logic [MAG_W:0]                rem_sh;
  logic [MAG_W+1:0]              rem_diff;
  logic signed [VALUE_W-1:0]     adj_sum;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid & cfg_ready;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_tvalid_r | out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Operand differences for the selected channel
  always_comb begin
    smp      = in_tdata[SAMPLE_BITS-1:0];
    sample_x = DIFF_W'(smp);
    if (in_tuser[0]) begin
      raw0_x   = DIFF_W'(signed'(h_raw0_r));
      raw1_x   = DIFF_W'(signed'(h_raw1_r));
      ref0_u   = h_ref0_x2_r[7:1];
      ref1_u   = h_ref1_x2_r[7:1];
      held_sel = held_h_r;
    end else begin
      raw0_x   = DIFF_W'(signed'(t_raw0_r));
      raw1_x   = DIFF_W'(signed'(t_raw1_r));
      ref0_u   = t_ref0_x8_r[9:3];
      ref1_u   = t_ref1_x8_r[9:3];
      held_sel = held_t_r;
    end
    ds      = sample_x - raw0_x;
    den_s   = raw1_x - raw0_x;
    dr      = signed'({1'b0, ref1_u}) - signed'({1'b0, ref0_u});
    ds_mag  = ds[DIFF_W-1] ? MAG_W'(-ds) : ds[MAG_W-1:0];
    den_mag = den_s[DIFF_W-1] ? MAG_W'(-den_s) : den_s[MAG_W-1:0];
    dr_mag  = dr[7] ? REFU_W'(-dr) : dr[REFU_W-1:0];
  end

  // Divider step: shift in next dividend bit, trial subtract
  assign rem_sh   = {rem_r, acc_r[PROD_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, den_r};
  // Offset add
  assign adj_sum  = signed'(res_r) + signed'(VALUE_W'(r0_r));

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    held_t_nxt     = held_t_r;
    held_h_nxt     = held_h_r;
    op_nxt         = op_r;
    neg_nxt        = neg_r;
    hold_nxt       = hold_r;
    fault_nxt      = fault_r;
    r0_nxt         = r0_r;
    mplier_nxt     = mplier_r;
    mcand_nxt      = mcand_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    // output register drains independently
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_tuser[0];
          r0_nxt     = ref0_u;
          mcand_nxt  = ds_mag;
          mplier_nxt = dr_mag;
          den_nxt    = den_mag;
          neg_nxt    = ds[DIFF_W-1] ^ den_s[DIFF_W-1] ^ dr[7];
          acc_nxt    = '0;
          rem_nxt    = '0;
          cnt_nxt    = '0;
          hold_nxt   = 1'b0;
          fault_nxt  = 1'b0;
          if ((held_sel != '0) && !in_tuser[1]) begin
            // held result returned without a conversion
            hold_nxt  = 1'b1;
            res_nxt   = held_sel;
            state_nxt = ST_DONE;
          end else if (den_s == '0) begin
            fault_nxt = 1'b1;
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // MSB-first shift-add over |r1 - r0|
        acc_nxt    = {acc_r[PROD_W-2:0], 1'b0}
                   + (mplier_r[REFU_W-1] ? PROD_W'(mcand_r) : '0);
        mplier_nxt = {mplier_r[REFU_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring divide, quotient shifts into acc
        if (!rem_diff[MAG_W+1]) begin
          rem_nxt = rem_diff[MAG_W-1:0];
          acc_nxt = {acc_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[MAG_W-1:0];
          acc_nxt = {acc_r[PROD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SGN;
        end
      end
      ST_SGN: begin
        // truncation toward zero: sign applied to the magnitude quotient
        res_nxt   = neg_r ? VALUE_W'(-{1'b0, acc_r}) : VALUE_W'(acc_r);
        state_nxt = ST_ADJ;
      end
      ST_ADJ: begin
        if (op_r && (adj_sum > VALUE_W'(HUMID_MAX))) begin
          res_nxt = VALUE_W'(HUMID_MAX);
        end else begin
          res_nxt = adj_sum;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          out_tuser_nxt  = {fault_r, hold_r};
          if (!hold_r && !fault_r) begin
            if (op_r) begin
              held_h_nxt = res_r;
            end else begin
              held_t_nxt = res_r;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      held_t_r     <= '0;
      held_h_r     <= '0;
      t_ref0_x8_r  <= '0;
      t_ref1_x8_r  <= '0;
      t_raw0_r     <= '0;
      t_raw1_r     <= '0;
      h_ref0_x2_r  <= '0;
      h_ref1_x2_r  <= '0;
      h_raw0_r     <= '0;
      h_raw1_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      held_t_r     <= held_t_nxt;
      held_h_r     <= held_h_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          REG_TEMP_REF0_X8:  t_ref0_x8_r <= cfg_data[9:0];
          REG_TEMP_REF1_X8:  t_ref1_x8_r <= cfg_data[9:0];
          REG_TEMP_REF0_RAW: t_raw0_r    <= cfg_data;
          REG_TEMP_REF1_RAW: t_raw1_r    <= cfg_data;
          REG_HUM_REF0_X2:   h_ref0_x2_r <= cfg_data[7:0];
          REG_HUM_REF1_X2:   h_ref1_x2_r <= cfg_data[7:0];
          REG_HUM_REF0_RAW:  h_raw0_r    <= cfg_data;
          REG_HUM_REF1_RAW:  h_raw1_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    neg_r       <= neg_nxt;
    hold_r      <= hold_nxt;
    fault_r     <= fault_nxt;
    r0_r        <= r0_nxt;
    mplier_r    <= mplier_nxt;
    mcand_r     <= mcand_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // Checks
  `SPC_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready, "input taken while busy")
  `SPC_ASSERT_NOW(a_fault_clean, out_tvalid_r && out_tuser_r[1], (out_tdata_r == '0) && !out_tuser_r[0], "fault result not zero")
  `SPC_ASSERT_NOW(a_div_count, state_r == ST_DIV, cnt_r < CNT_W'(DIV_STEPS), "divide step count overrun")
  `SPC_ASSERT_NOW(a_humid_clamp, 1'b1, signed'(held_h_r) <= signed'(VALUE_W'(HUMID_MAX)), "held humidity above clamp")

endmodule

@@ dv/sensor_two_point_calibrator_tb.sv @@
// Self-checking testbench for sensor_two_point_calibrator: directed and random
// sample words checked against an in-bench calibration predictor.
// Depends on spc_pkg and the sensor_two_point_calibrator RTL.
`timescale 1ns / 1ps

module sensor_two_point_calibrator_tb;
  import spc_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 210;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'hF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'h8;

  // One input word: channel select, raw count, new-sample flag
  typedef struct packed {
    logic              op;
    logic [SAMPLE_W-1:0] raw;
    logic              ready;
  } sample_word_t;

  // One result word
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               hold;
    logic               fault;
  } reading_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic [1:0]          in_tuser = '0;

  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;
  logic [1:0]         out_tuser;

  sensor_two_point_calibrator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Calibration registers as the block should hold them
  logic [9:0]         temp_pt_x8 [2];
  logic signed [15:0] temp_cnt   [2];
  logic [7:0]         humid_pt_x2 [2];
  logic signed [15:0] humid_cnt  [2];
  // Last good result per channel: index 0 temperature, 1 humidity
  longint             held_level [2];

  sample_word_t sample_words [$];
  reading_t     expected_readings [$];
  sample_word_t on_bus = '0;
  sample_word_t next_word;
  int           words_in = 0;
  int           mismatches = 0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  bit           pressure_armed = 1'b0;
  int           holdoff_left = 0;
  bit           holdoff_used = 1'b0;
  int           quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected result of one word; updates the held value as the block does
  function automatic reading_t calibrate(sample_word_t w);
    reading_t r;
    longint pt0, pt1, cnt0, cnt1, smp, num, den, val;
    r = '0;
    smp = longint'($signed(w.raw));
    if (held_level[w.op] != 0 && !w.ready) begin
      r.value = held_level[w.op][VALUE_W-1:0];
      r.hold  = 1'b1;
      return r;
    end
    if (w.op) begin
      pt0  = longint'(humid_pt_x2[0]) / 2;
      pt1  = longint'(humid_pt_x2[1]) / 2;
      cnt0 = longint'(humid_cnt[0]);
      cnt1 = longint'(humid_cnt[1]);
    end else begin
      pt0  = longint'(temp_pt_x8[0]) / 8;
      pt1  = longint'(temp_pt_x8[1]) / 8;
      cnt0 = longint'(temp_cnt[0]);
      cnt1 = longint'(temp_cnt[1]);
    end
    den = cnt1 - cnt0;
    if (den == 0) begin
      // equal reference counts: flagged, held value untouched
      r.fault = 1'b1;
      return r;
    end
    num = (pt1 - pt0) * (smp - cnt0);
    val = num / den + pt0;
    if (w.op && val > HUMID_MAX) val = HUMID_MAX;
    held_level[w.op] = val;
    r.value = val[VALUE_W-1:0];
    return r;
  endfunction

  // Sender: feeds queued words, random gaps per phase
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(calibrate(on_bus));
        words_in <= words_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_word = sample_words.pop_front();
          on_bus    <= next_word;
          in_tdata  <= next_word.raw;
          in_tuser  <= {next_word.ready, next_word.op};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_left <= 0;
      holdoff_used <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (pressure_armed && !holdoff_used && words_in >= 40) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_used <= 1'b1;
    end
  end

  // Receiver ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (holdoff_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result checker
  reading_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result word: scaled_value %0d", $signed(out_tdata));
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (out_tdata !== want.value) begin
          $error("scaled_value: expected %0d, got %0d", $signed(want.value),
                 $signed(out_tdata));
          mismatches++;
        end
        if (out_tuser[0] !== want.hold) begin
          $error("from_hold: expected %0b, got %0b", want.hold, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.fault) begin
          $error("divide_fault: expected %0b, got %0b", want.fault, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One register write; the predictor copy follows the accepted write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEMP_REF0_X8:  temp_pt_x8[0]  = data[9:0];
      REG_TEMP_REF1_X8:  temp_pt_x8[1]  = data[9:0];
      REG_TEMP_REF0_RAW: temp_cnt[0]    = data;
      REG_TEMP_REF1_RAW: temp_cnt[1]    = data;
      REG_HUM_REF0_X2:   humid_pt_x2[0] = data[7:0];
      REG_HUM_REF1_X2:   humid_pt_x2[1] = data[7:0];
      REG_HUM_REF0_RAW:  humid_cnt[0]   = data;
      REG_HUM_REF1_RAW:  humid_cnt[1]   = data;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] t0x8, t1x8, t0raw, t1raw,
                           input logic [15:0] h0x2, h1x2, h0raw, h1raw);
    write_reg(REG_TEMP_REF0_X8, t0x8);
    write_reg(REG_TEMP_REF1_X8, t1x8);
    write_reg(REG_TEMP_REF0_RAW, t0raw);
    write_reg(REG_TEMP_REF1_RAW, t1raw);
    write_reg(REG_HUM_REF0_X2, h0x2);
    write_reg(REG_HUM_REF1_X2, h1x2);
    write_reg(REG_HUM_REF0_RAW, h0raw);
    write_reg(REG_HUM_REF1_RAW, h1raw);
  endtask

  // Second raw count: mostly random, sometimes equal or one apart
  function automatic logic [15:0] pick_second_count(logic [15:0] first);
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return first;
    if (pick == 1) return first + 16'd1;
    if (pick == 2) return first - 16'd1;
    return 16'($urandom);
  endfunction

  task automatic push_word(input logic op, input logic [15:0] raw, input logic ready);
    sample_words.push_back('{op: op, raw: raw, ready: ready});
  endtask

  task automatic wait_drained();
    while (sample_words.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(negedge clk);
  endtask

  // Random word: full range, extremes, or close to a reference count
  function automatic sample_word_t random_word();
    sample_word_t w;
    logic [15:0] base;
    logic        pt_sel;
    w.op    = 1'($urandom_range(1));
    w.ready = $urandom_range(99) < 60;
    pt_sel  = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: w.raw = 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0: w.raw = 16'h8000;
          1: w.raw = 16'h7FFF;
          2: w.raw = 16'h0000;
          default: w.raw = 16'hFFFF;
        endcase
      end
      default: begin
        base  = w.op ? humid_cnt[pt_sel] : temp_cnt[pt_sel];
        w.raw = base + 16'($urandom_range(600)) - 16'd300;
      end
    endcase
    return w;
  endfunction

  initial begin
    logic [15:0] c0, c1;
    temp_pt_x8  = '{default: '0};
    temp_cnt    = '{default: '0};
    humid_pt_x2 = '{default: '0};
    humid_cnt   = '{default: '0};
    held_level  = '{default: 0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: equal counts everywhere, held values zero
    push_word(1'b0, 16'h0000, 1'b1);
    push_word(1'b1, 16'h7FFF, 1'b0);
    push_word(1'b0, 16'h8000, 1'b0);
    wait_drained();

    // Full-scale temperature, wide humidity span; upper data bits set to be dropped
    write_all(16'hFC00, 16'hFFFF, 16'h8000, 16'h7FFF,
              16'hFF00, 16'h00FF, 16'(-20000), 16'd20000);
    write_reg(REG_UNUSED_HI, 16'h5A5A);
    write_reg(REG_UNUSED_LO, 16'hA5A5);
    @(negedge clk);
    push_word(1'b0, 16'h8000, 1'b1);    // converts to zero
    push_word(1'b0, 16'h8000, 1'b0);    // held zero: converts anyway
    push_word(1'b0, 16'h7FFF, 1'b1);
    push_word(1'b0, 16'h0000, 1'b0);    // hold
    push_word(1'b0, 16'hFFFF, 1'b1);
    push_word(1'b0, 16'h0001, 1'b0);    // hold
    push_word(1'b1, 16'd20000, 1'b1);   // clamps at the top
    push_word(1'b1, 16'h7FFF, 1'b0);    // hold
    push_word(1'b1, 16'h0000, 1'b1);
    push_word(1'b1, 16'h8000, 1'b1);    // negative, not clamped
    push_word(1'b1, 16'h8000, 1'b0);    // hold
    push_word(1'b0, 16'h5555, 1'b1);
    push_word(1'b1, 16'hAAAA, 1'b1);
    wait_drained();

    // Equal reference counts: faults keep the held values
    write_reg(REG_TEMP_REF0_RAW, 16'h1234);
    write_reg(REG_TEMP_REF1_RAW, 16'h1234);
    write_reg(REG_HUM_REF0_RAW, 16'hFFFF);
    write_reg(REG_HUM_REF1_RAW, 16'hFFFF);
    @(negedge clk);
    push_word(1'b0, 16'h0000, 1'b1);
    push_word(1'b0, 16'h0000, 1'b0);
    push_word(1'b1, 16'h7FFF, 1'b1);
    push_word(1'b1, 16'h0000, 1'b0);
    wait_drained();

    // Random phases over idle modes and calibration settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_all(16'd0, 16'd1023, 16'h8000, 16'h8001,
                     16'd0, 16'd255, 16'h8000, 16'h8001);
        1: write_all(16'd1023, 16'd0, 16'h7FFF, 16'h7FFE,
                     16'd255, 16'd0, 16'h7FFF, 16'h7FFE);
        default: begin
          write_reg(REG_TEMP_REF0_X8, 16'($urandom));
          write_reg(REG_TEMP_REF1_X8, 16'($urandom));
          c0 = 16'($urandom);
          c1 = pick_second_count(c0);
          write_reg(REG_TEMP_REF0_RAW, c0);
          write_reg(REG_TEMP_REF1_RAW, c1);
          write_reg(REG_HUM_REF0_X2, 16'($urandom));
          write_reg(REG_HUM_REF1_X2, 16'($urandom));
          c0 = 16'($urandom);
          c1 = pick_second_count(c0);
          write_reg(REG_HUM_REF0_RAW, c0);
          write_reg(REG_HUM_REF1_RAW, c1);
        end
      endcase
      @(negedge clk);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      pressure_armed = (p == 0);
      for (int i = 0; i < WORDS_PER_PHASE; i++) sample_words.push_back(random_word());
      wait_drained();
    end

    // Let any stray result show up
    repeat (40) @(posedge clk);
    if (expected_readings.size() != 0) begin
      $error("%0d expected result words never arrived", expected_readings.size());
    end
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
